/* rtl/gta_pkg.sv */
// Shared types, codes and tables for the gamepad turbo autofire block.
package gta_pkg;

	localparam int NUM_PADS = 4;      // pads fitted, 1 to 4
	localparam int SLOTS = 4;         // pad slots on the ports
	localparam int BTN_W = 8;
	localparam int PAD_IDX_W = 2;
	localparam int SPEED_W = 3;
	localparam int CNT_W = 4;
	localparam logic [SPEED_W-1:0] SPEED_RESET = 3'd6;
	localparam logic [CNT_W-1:0] MAX_LEN = 4'd10;

	localparam logic KIND_BUTTON = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	localparam logic [1:0] EVT_NORMAL = 2'd0;
	localparam logic [1:0] EVT_HOLD = 2'd1;
	localparam logic [1:0] EVT_TOGGLE = 2'd2;

	typedef logic [BTN_W-1:0] btn_t;

	typedef struct packed {
		logic       en;
		logic       pressed;
		logic [1:0] evt;
		btn_t       mask;
	} pad_evt_t;

	// turbo cycle length in frames
	function automatic logic [CNT_W-1:0] cycle_len(input logic [SPEED_W-1:0] speed);
		logic [CNT_W-1:0] len;
		unique case (speed)
			3'd0: len = 4'd1;
			3'd1: len = 4'd10;
			3'd2: len = 4'd8;
			3'd3: len = 4'd6;
			3'd4: len = 4'd5;
			3'd5: len = 4'd4;
			3'd6: len = 4'd3;
			3'd7: len = 4'd2;
			default: len = 4'd1;
		endcase
		return len;
	endfunction

	// frames of the on phase: ceil(len/2)
	function automatic logic [CNT_W-1:0] on_frames(input logic [SPEED_W-1:0] speed);
		logic [CNT_W-1:0] n;
		unique case (speed)
			3'd0: n = 4'd1;
			3'd1: n = 4'd5;
			3'd2: n = 4'd4;
			3'd3: n = 4'd3;
			3'd4: n = 4'd3;
			3'd5: n = 4'd2;
			3'd6: n = 4'd2;
			3'd7: n = 4'd1;
			default: n = 4'd1;
		endcase
		return n;
	endfunction

endpackage

/* rtl/gta_pad.sv */
// Button state of one pad and its effective buttons after turbo gating.
module gta_pad (
	input  logic              clk,
	input  logic              arst_n,
	input  gta_pkg::pad_evt_t evt,
	input  logic              phase_next,
	output gta_pkg::btn_t     effective_next
);

	gta_pkg::btn_t held_q, turbo_q, toggle_q;
	gta_pkg::btn_t held_d, turbo_d, toggle_d;

	always_comb begin
		held_d = held_q;
		turbo_d = turbo_q;
		toggle_d = toggle_q;
		if (evt.en) begin
			unique case (evt.evt)
				gta_pkg::EVT_NORMAL: held_d = evt.pressed ? (held_q | evt.mask)
				                                          : (held_q & ~evt.mask);
				gta_pkg::EVT_HOLD: turbo_d = evt.pressed ? (turbo_q | evt.mask)
				                                         : (turbo_q & ~evt.mask);
				gta_pkg::EVT_TOGGLE: if (evt.pressed) begin
					toggle_d = toggle_q ^ evt.mask;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			turbo_q <= '0;
			toggle_q <= '0;
		end else begin
			held_q <= held_d;
			turbo_q <= turbo_d;
			toggle_q <= toggle_d;
		end
	end

	// plain buttons always show; toggled and turbo buttons follow the phase
	assign effective_next = (held_d & ~toggle_d)
	                      | (((held_d & toggle_d) | turbo_d) & {gta_pkg::BTN_W{phase_next}});

endmodule

/* rtl/gamepad_turbo_autofire.sv */
// Four-pad autofire controller: button state, frame counter and gated outputs.
// An item's transfer loads the input register; its result is then registered in the result
// register when that is empty or out_stall is low, and holds until it transfers.
// Throughput: one item per cycle while out_stall is low; the state update is combinational.
// in_stall rises only when both registers hold an item and out_stall is high.
// Reset (arst_n low, asynchronous): all button state and the frame counter cleared,
// phase off, speed register back to 6, both registers empty.
module gamepad_turbo_autofire (
	input  logic                            clk,
	input  logic                            arst_n,
	// item channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            kind,
	input  logic [gta_pkg::PAD_IDX_W-1:0]   pad_index,
	input  logic [gta_pkg::BTN_W-1:0]       button_mask,
	input  logic                            pressed,
	input  logic [1:0]                      event_type,
	// result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [gta_pkg::BTN_W-1:0]       pad0_effective,
	output logic [gta_pkg::BTN_W-1:0]       pad1_effective,
	output logic [gta_pkg::BTN_W-1:0]       pad2_effective,
	output logic [gta_pkg::BTN_W-1:0]       pad3_effective,
	output logic                            phase_on,
	// speed register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gta_pkg::SPEED_W-1:0]     cfg_data
);

	// ---------------- configuration ----------------
	// Always ready; the new speed is seen at the next frame tick.
	logic [gta_pkg::SPEED_W-1:0] speed_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= gta_pkg::SPEED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			speed_q <= cfg_data;
		end
	end

	// ---------------- input register ----------------
	logic                          valid_s1;
	logic                          kind_s1;
	logic [gta_pkg::PAD_IDX_W-1:0] pad_s1;
	gta_pkg::btn_t                 mask_s1;
	logic                          pressed_s1;
	logic [1:0]                    evt_s1;

	logic out_valid_q;
	logic in_xfer;
	logic adv;         // stage 1 item moves into the result register

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_xfer = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_s1 <= kind;
			pad_s1 <= pad_index;
			mask_s1 <= button_mask;
			pressed_s1 <= pressed;
			evt_s1 <= event_type;
		end
	end

	// ---------------- frame counter and fire phase ----------------
	logic [gta_pkg::CNT_W-1:0] count_q, count_d;
	logic                      phase_q, phase_d;
	logic [gta_pkg::CNT_W:0]   count_inc;
	logic [gta_pkg::CNT_W-1:0] len;
	logic                      tick;

	assign tick = adv && (kind_s1 == gta_pkg::KIND_FRAME);
	assign len = gta_pkg::cycle_len(speed_q);
	assign count_inc = {1'b0, count_q} + {{gta_pkg::CNT_W{1'b0}}, 1'b1};

	always_comb begin
		count_d = count_q;
		phase_d = phase_q;
		if (tick) begin
			// wrap also catches a counter left above a shorter length
			if (count_inc >= {1'b0, len}) begin
				count_d = '0;
			end else begin
				count_d = count_inc[gta_pkg::CNT_W-1:0];
			end
			phase_d = (count_d < gta_pkg::on_frames(speed_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			phase_q <= 1'b0;
		end else begin
			count_q <= count_d;
			phase_q <= phase_d;
		end
	end

	// ---------------- per-pad state ----------------
	gta_pkg::btn_t eff_d [gta_pkg::SLOTS];

	for (genvar p = 0; p < gta_pkg::SLOTS; p++) begin : g_pad
		if (p < gta_pkg::NUM_PADS) begin : g_fitted
			gta_pkg::pad_evt_t pevt;

			assign pevt.en = adv && (kind_s1 == gta_pkg::KIND_BUTTON)
			               && (pad_s1 == p[gta_pkg::PAD_IDX_W-1:0]);
			assign pevt.pressed = pressed_s1;
			assign pevt.evt = evt_s1;
			assign pevt.mask = mask_s1;

			gta_pad u_pad (
				.clk            (clk),
				.arst_n         (arst_n),
				.evt            (pevt),
				.phase_next     (phase_d),
				.effective_next (eff_d[p])
			);
		end else begin : g_absent
			// no pad in this slot: events ignored, output reads zero
			assign eff_d[p] = '0;
		end
	end

	// ---------------- result register ----------------
	gta_pkg::btn_t eff_q [gta_pkg::SLOTS];
	logic          phase_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < gta_pkg::SLOTS; i++) begin
				eff_q[i] <= eff_d[i];
			end
			phase_out_q <= phase_d;
		end
	end

	assign out_valid = out_valid_q;
	assign pad0_effective = eff_q[0];
	assign pad1_effective = eff_q[1];
	assign pad2_effective = eff_q[2];
	assign pad3_effective = eff_q[3];
	assign phase_on = phase_out_q;

`ifndef SYNTHESIS
	// counter never reaches the longest cycle length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < gta_pkg::MAX_LEN)
		else $error("frame counter out of range");

	// a button event leaves the frame counter and phase alone
	a_button_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && kind_s1 == gta_pkg::KIND_BUTTON) |=> ($stable(count_q) && $stable(phase_q)))
		else $error("button event moved the frame counter");

	// after a tick the phase matches the new counter position
	a_tick_phase: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> (phase_q == (count_q < gta_pkg::on_frames(speed_q))))
		else $error("fire phase disagrees with frame counter");

	// after an advance the published phase equals the state phase
	a_out_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_valid_q && phase_out_q == phase_q))
		else $error("result phase mismatch");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the four-pad turbo autofire block.
module testbench;
	import gta_pkg::*;

	// event_type 3 is not decoded by the block and must leave every pad alone
	localparam logic [1:0] EVT_SPARE = 2'd3;

	// turbo cycle length in frames, indexed by the speed register
	localparam int unsigned TURBO_LEN [8] = '{1, 10, 8, 6, 5, 4, 3, 2};

	// speed settings walked by the random phases; extremes 0, 1 and 7 all appear
	localparam logic [SPEED_W-1:0] SPEED_PLAN [10] = '{3'd1, 3'd0, 3'd7, 3'd3, 3'd4,
		3'd2, 3'd5, 3'd6, 3'd1, 3'd7};
	localparam int ITEMS_PER_PHASE = 123;
	localparam int HOLD_CYCLES = 64;

	// one input transfer
	typedef struct packed {
		logic       kind;
		logic [1:0] pad;
		btn_t       mask;
		logic       pressed;
		logic [1:0] evt;
	} pad_item_t;

	// one result transfer
	typedef struct packed {
		btn_t p0;
		btn_t p1;
		btn_t p2;
		btn_t p3;
		logic phase;
	} pads_out_t;

	// directed row: 'typed' rows carry their expected result, the rest use the predictor
	typedef struct packed {
		pad_item_t item;
		logic      typed;
		pads_out_t want;
	} stim_row_t;

	// Directed part. Starts straight after reset at the reset speed (cycle of 3,
	// on phase for 2 frames), so turbo buttons stay dark until the first tick.
	localparam stim_row_t SCRIPT [22] = '{
		// full-mask normal press and release on pad 0
		'{'{KIND_BUTTON, 2'd0, 8'hFF, 1'b1, EVT_NORMAL}, 1'b1, '{8'hFF, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{'{KIND_BUTTON, 2'd0, 8'hFF, 1'b0, EVT_NORMAL}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		// turbo hold before any tick: phase off, nothing shows
		'{'{KIND_BUTTON, 2'd1, 8'hFF, 1'b1, EVT_HOLD},   1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		// toggle release and the spare event type do nothing
		'{'{KIND_BUTTON, 2'd2, 8'hFF, 1'b0, EVT_TOGGLE}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{'{KIND_BUTTON, 2'd3, 8'hFF, 1'b1, EVT_SPARE},  1'b1, '{8'h00, 8'h00, 8'h00, 8'h00, 1'b0}},
		'{'{KIND_BUTTON, 2'd3, 8'h80, 1'b1, EVT_NORMAL}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h80, 1'b0}},
		// first tick: count 1, on phase, pad 1 turbo fires
		'{'{KIND_FRAME,  2'd0, 8'h00, 1'b0, EVT_NORMAL}, 1'b1, '{8'h00, 8'hFF, 8'h00, 8'h80, 1'b1}},
		// tick with junk in the ignored fields: count 2, off phase
		'{'{KIND_FRAME,  2'd3, 8'hFF, 1'b1, EVT_TOGGLE}, 1'b1, '{8'h00, 8'h00, 8'h00, 8'h80, 1'b0}},
		// the rest is checked by the predictor
		'{'{KIND_BUTTON, 2'd2, 8'h55, 1'b1, EVT_TOGGLE}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd2, 8'hFF, 1'b1, EVT_NORMAL}, 1'b0, '0},
		'{'{KIND_FRAME,  2'd0, 8'h00, 1'b0, EVT_NORMAL}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd2, 8'h55, 1'b1, EVT_TOGGLE}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd1, 8'h0F, 1'b0, EVT_HOLD},   1'b0, '0},
		'{'{KIND_BUTTON, 2'd0, 8'h01, 1'b1, EVT_TOGGLE}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd0, 8'h01, 1'b1, EVT_NORMAL}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd3, 8'h7F, 1'b1, EVT_HOLD},   1'b0, '0},
		'{'{KIND_FRAME,  2'd1, 8'hAA, 1'b0, EVT_HOLD},   1'b0, '0},
		'{'{KIND_BUTTON, 2'd3, 8'hFF, 1'b0, EVT_NORMAL}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd2, 8'hFF, 1'b0, EVT_SPARE},  1'b0, '0},
		'{'{KIND_FRAME,  2'd0, 8'h00, 1'b0, EVT_NORMAL}, 1'b0, '0},
		'{'{KIND_BUTTON, 2'd3, 8'hFF, 1'b0, EVT_HOLD},   1'b0, '0},
		'{'{KIND_BUTTON, 2'd0, 8'h01, 1'b0, EVT_TOGGLE}, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 kind = KIND_BUTTON;
	logic [PAD_IDX_W-1:0] pad_index = '0;
	btn_t                 button_mask = '0;
	logic                 pressed = 1'b0;
	logic [1:0]           event_type = EVT_NORMAL;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	btn_t                 pad0_effective;
	btn_t                 pad1_effective;
	btn_t                 pad2_effective;
	btn_t                 pad3_effective;
	logic                 phase_on;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [SPEED_W-1:0]   cfg_data = '0;

	// predictor state, mirrors the block's registers
	btn_t             held [SLOTS];
	btn_t             turbo [SLOTS];
	btn_t             toggled [SLOTS];
	logic [CNT_W-1:0] frame_no = '0;
	logic             fire_on = 1'b0;
	logic [SPEED_W-1:0] speed = SPEED_RESET;

	pads_out_t pads_due [$];   // results still owed by the block, oldest first

	int unsigned gap_pct = 0;     // chance per cycle that the sender idles
	int unsigned stall_pct = 0;   // chance per cycle that the receiver stalls
	int unsigned hold_epoch = 0;  // bumped by the stimulus to ask for a long hold-off
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned ticks_sent = 0;
	int unsigned results_checked = 0;

	gamepad_turbo_autofire dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.kind           (kind),
		.pad_index      (pad_index),
		.button_mask    (button_mask),
		.pressed        (pressed),
		.event_type     (event_type),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pad0_effective (pad0_effective),
		.pad1_effective (pad1_effective),
		.pad2_effective (pad2_effective),
		.pad3_effective (pad3_effective),
		.phase_on       (phase_on),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advances the predicted state by one item and returns the result it owes.
	// A tick moves the frame counter (wrapping once it reaches the cycle length,
	// which also pulls a counter left high by a speed change back to zero) and
	// recomputes the phase; a button event updates one pad.
	function automatic pads_out_t autofire_step(input pad_item_t it);
		int unsigned len;
		int unsigned on_len;
		int unsigned nxt;
		btn_t eff [SLOTS];
		pads_out_t r;
		if (it.kind == KIND_FRAME) begin
			len = TURBO_LEN[speed];
			on_len = (len + 1) / 2;
			nxt = frame_no + 1;
			if (nxt >= len)
				nxt = 0;
			frame_no = nxt[CNT_W-1:0];
			fire_on = (frame_no < on_len);
		end else if (it.pad < NUM_PADS) begin
			case (it.evt)
				EVT_NORMAL: held[it.pad] = it.pressed ? (held[it.pad] | it.mask)
					: (held[it.pad] & ~it.mask);
				EVT_HOLD: turbo[it.pad] = it.pressed ? (turbo[it.pad] | it.mask)
					: (turbo[it.pad] & ~it.mask);
				// toggles flip on press only
				EVT_TOGGLE: if (it.pressed) toggled[it.pad] = toggled[it.pad] ^ it.mask;
				default: ;  // spare type: no effect
			endcase
		end
		for (int p = 0; p < SLOTS; p++) begin
			if (p < NUM_PADS)
				eff[p] = (held[p] & ~toggled[p])
					| (((held[p] & toggled[p]) | turbo[p]) & {BTN_W{fire_on}});
			else
				eff[p] = '0;
		end
		r = '{eff[0], eff[1], eff[2], eff[3], fire_on};
		return r;
	endfunction

	// Random item: about a quarter are frame ticks; masks lean towards single
	// buttons, all-on and all-off so that held/turbo/toggle bits come and go.
	function automatic pad_item_t random_item();
		pad_item_t it;
		it.kind = ($urandom_range(99) < 25) ? KIND_FRAME : KIND_BUTTON;
		it.pad = 2'($urandom_range(SLOTS - 1));
		case ($urandom_range(3))
			0: it.mask = 8'h01 << $urandom_range(7);
			1: it.mask = $urandom_range(1) ? 8'hFF : 8'h00;
			default: it.mask = 8'($urandom_range(255));
		endcase
		it.pressed = 1'($urandom_range(1));
		it.evt = ($urandom_range(9) == 0) ? EVT_SPARE : 2'($urandom_range(2));
		return it;
	endfunction

	// Offers one item, with random idle cycles in front, and waits for its transfer.
	// Called at a rising edge; returns at the edge where the transfer took place,
	// leaving in_valid high so back-to-back items need no second assignment.
	task automatic send_item(input pad_item_t it, input logic typed, input pads_out_t want);
		pads_out_t due;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{kind, pad_index, button_mask, pressed, event_type} <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		due = autofire_step(it);
		pads_due.push_back(typed ? want : due);
		items_sent++;
		if (it.kind == KIND_FRAME)
			ticks_sent++;
	endtask

	// Writes the speed register once the block has drained. Every item yields a
	// result, so an empty queue means the pipe is empty.
	task automatic write_speed(input logic [SPEED_W-1:0] s);
		in_valid <= 1'b0;
		while (pads_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= s;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		speed = s;
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// Receiver: random stalls, plus a long hold-off on request so the block
	// fills both registers and has to stall its input.
	always @(posedge clk) begin
		if (hold_epoch != hold_seen) begin
			hold_seen <= hold_epoch;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Result checker: each result transfer against the oldest outstanding prediction.
	always @(posedge clk) begin
		pads_out_t got;
		pads_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pad0_effective, pad1_effective, pad2_effective, pad3_effective, phase_on};
			if (pads_due.size() == 0) begin
				$error("result transfer with nothing outstanding");
				errors++;
			end else begin
				want = pads_due.pop_front();
				check_field("pad0_effective", int'(want.p0), int'(got.p0));
				check_field("pad1_effective", int'(want.p1), int'(got.p1));
				check_field("pad2_effective", int'(want.p2), int'(got.p2));
				check_field("pad3_effective", int'(want.p3), int'(got.p3));
				check_field("phase_on", int'(want.phase), int'(got.phase));
				results_checked++;
			end
		end
	end

	// Stimulus: reset, directed table at the reset speed, then ten random
	// phases, each with its own speed setting. Idling: sender rarely idles and
	// receiver often stalls, then the reverse, then neither; one long hold-off
	// lands in the last stretch.
	initial begin
		for (int p = 0; p < SLOTS; p++) begin
			held[p] = '0;
			turbo[p] = '0;
			toggled[p] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct = 7;
		stall_pct <= 56;
		foreach (SCRIPT[i])
			send_item(SCRIPT[i].item, SCRIPT[i].typed, SCRIPT[i].want);
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 3) begin
				gap_pct = 56;
				stall_pct <= 7;
			end else if (ph == 6) begin
				gap_pct = 0;
				stall_pct <= 0;
			end
			write_speed(SPEED_PLAN[ph]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (ph == 7 && n == 40)
					hold_epoch <= hold_epoch + 1;
				send_item(random_item(), 1'b0, '0);
			end
		end
		in_valid <= 1'b0;
		while (pads_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("summary: %0d items (%0d frame ticks), %0d results checked,",
			items_sent, ticks_sent, results_checked);
		$display("summary: %0d speed settings incl. 0, 1 and 7, %0d mismatches",
			$size(SPEED_PLAN), errors);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Watchdog: far beyond the slowest legitimate run.
	initial begin
		#2000000;
		$display("testbench: errors");
		$finish;
	end

endmodule

/* sim.f */
rtl/gta_pkg.sv
rtl/gta_pad.sv
rtl/gamepad_turbo_autofire.sv
tb/testbench.sv
